FILE: hw/rtl/autorange_gain_measure_core_defines.svh
// ----------------------------------------------------------------------------
// Autorange gain measure core: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AUTORANGE_GAIN_MEASURE_CORE_DEFINES_SVH
`define AUTORANGE_GAIN_MEASURE_CORE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define AGM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define AGM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/agm_pkg.sv
// ----------------------------------------------------------------------------
// Autorange gain measure package
// Types, register indexes, codes and constant tables shared by the core.
// ----------------------------------------------------------------------------
package agm_pkg;

	localparam int WINDOW_SAMPLES = 1000;
	localparam int WIN_W          = $clog2(WINDOW_SAMPLES);

	localparam int LEVEL_W = 16;
	localparam int RES_W   = 19;
	localparam int PROG_W  = 7;
	localparam int TICK_W  = 6;

	// Register indexes.
	localparam logic [2:0] REG_AUTO_RANGE     = 3'd0;
	localparam logic [2:0] REG_FIXED_GAIN     = 3'd1;
	localparam logic [2:0] REG_LOW_LEVEL      = 3'd2;
	localparam logic [2:0] REG_MID_LEVEL      = 3'd3;
	localparam logic [2:0] REG_HIGH_LEVEL     = 3'd4;
	localparam logic [2:0] REG_SETTLE_TICKS   = 3'd5;
	localparam logic [2:0] REG_POLARITY_LEVEL = 3'd6;

	// Register reset values.
	localparam logic                AUTO_RANGE_RST     = 1'b1;
	localparam logic [1:0]          FIXED_GAIN_RST     = 2'd2;
	localparam logic [LEVEL_W-1:0]  LOW_LEVEL_RST      = 16'd528;
	localparam logic [LEVEL_W-1:0]  MID_LEVEL_RST      = 16'd5280;
	localparam logic [LEVEL_W-1:0]  HIGH_LEVEL_RST     = 16'd44800;
	localparam logic [TICK_W-1:0]   SETTLE_TICKS_RST   = 6'd10;
	localparam logic [LEVEL_W-1:0]  POLARITY_LEVEL_RST = 16'd600;

	// Gain codes as reported.
	localparam logic [1:0] GAIN_X1   = 2'd0;
	localparam logic [1:0] GAIN_X10  = 2'd1;
	localparam logic [1:0] GAIN_X100 = 2'd2;

	// Fixed gain register codes.
	localparam logic [1:0] FG_X100 = 2'd0;
	localparam logic [1:0] FG_X10  = 2'd1;
	localparam logic [1:0] FG_X1   = 2'd2;
	localparam logic [1:0] FG_KEEP = 2'd3;

	// Reported phase codes.
	localparam logic [2:0] PH_IDLE_CODE     = 3'd0;
	localparam logic [2:0] PH_FIXED_CODE    = 3'd1;
	localparam logic [2:0] PH_CHECK_CODE    = 3'd2;
	localparam logic [2:0] PH_AVERAGE_CODE  = 3'd3;
	localparam logic [2:0] PH_COMPLETE_CODE = 3'd4;

	localparam logic [PROG_W-1:0] PROG_START = 7'd1;
	localparam logic [PROG_W-1:0] PROG_FIXED = 7'd50;
	localparam logic [PROG_W-1:0] PROG_RANGE = 7'd80;
	localparam logic [PROG_W-1:0] PROG_FULL  = 7'd100;
	localparam logic [5:0]        SETTLE_PCT = 6'd50;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_FIXED    = 5'b00010,
		PH_CHECK    = 5'b00100,
		PH_AVERAGE  = 5'b01000,
		PH_COMPLETE = 5'b10000
	} phase_t;

	typedef struct packed {
		logic               auto_range;
		logic [1:0]         fixed_gain;
		logic [LEVEL_W-1:0] low_level;
		logic [LEVEL_W-1:0] mid_level;
		logic [LEVEL_W-1:0] high_level;
		logic [TICK_W-1:0]  settle_ticks;
		logic [LEVEL_W-1:0] polarity_level;
	} cfg_t;

	// Division by the gain as multiplication by a rounded-up reciprocal.
	localparam int          DIV10_SHIFT  = 22;
	localparam int          DIV100_SHIFT = 26;
	localparam logic [19:0] RECIP_DIV10  = 20'((2**DIV10_SHIFT + 9) / 10);
	localparam logic [19:0] RECIP_DIV100 = 20'((2**DIV100_SHIFT + 99) / 100);

	// Rounded-up reciprocals of the settle tick count; a count of zero acts as one.
	localparam int SETTLE_SHIFT = 18;
	localparam int RECIP_ONE    = 2**SETTLE_SHIFT;
	localparam int SRC_W        = SETTLE_SHIFT + 1;

	localparam logic [SRC_W-1:0] SETTLE_RECIP [0:63] = '{
		19'(RECIP_ONE),              19'(RECIP_ONE),
		19'((RECIP_ONE + 1) / 2),    19'((RECIP_ONE + 2) / 3),
		19'((RECIP_ONE + 3) / 4),    19'((RECIP_ONE + 4) / 5),
		19'((RECIP_ONE + 5) / 6),    19'((RECIP_ONE + 6) / 7),
		19'((RECIP_ONE + 7) / 8),    19'((RECIP_ONE + 8) / 9),
		19'((RECIP_ONE + 9) / 10),   19'((RECIP_ONE + 10) / 11),
		19'((RECIP_ONE + 11) / 12),  19'((RECIP_ONE + 12) / 13),
		19'((RECIP_ONE + 13) / 14),  19'((RECIP_ONE + 14) / 15),
		19'((RECIP_ONE + 15) / 16),  19'((RECIP_ONE + 16) / 17),
		19'((RECIP_ONE + 17) / 18),  19'((RECIP_ONE + 18) / 19),
		19'((RECIP_ONE + 19) / 20),  19'((RECIP_ONE + 20) / 21),
		19'((RECIP_ONE + 21) / 22),  19'((RECIP_ONE + 22) / 23),
		19'((RECIP_ONE + 23) / 24),  19'((RECIP_ONE + 24) / 25),
		19'((RECIP_ONE + 25) / 26),  19'((RECIP_ONE + 26) / 27),
		19'((RECIP_ONE + 27) / 28),  19'((RECIP_ONE + 28) / 29),
		19'((RECIP_ONE + 29) / 30),  19'((RECIP_ONE + 30) / 31),
		19'((RECIP_ONE + 31) / 32),  19'((RECIP_ONE + 32) / 33),
		19'((RECIP_ONE + 33) / 34),  19'((RECIP_ONE + 34) / 35),
		19'((RECIP_ONE + 35) / 36),  19'((RECIP_ONE + 36) / 37),
		19'((RECIP_ONE + 37) / 38),  19'((RECIP_ONE + 38) / 39),
		19'((RECIP_ONE + 39) / 40),  19'((RECIP_ONE + 40) / 41),
		19'((RECIP_ONE + 41) / 42),  19'((RECIP_ONE + 42) / 43),
		19'((RECIP_ONE + 43) / 44),  19'((RECIP_ONE + 44) / 45),
		19'((RECIP_ONE + 45) / 46),  19'((RECIP_ONE + 46) / 47),
		19'((RECIP_ONE + 47) / 48),  19'((RECIP_ONE + 48) / 49),
		19'((RECIP_ONE + 49) / 50),  19'((RECIP_ONE + 50) / 51),
		19'((RECIP_ONE + 51) / 52),  19'((RECIP_ONE + 52) / 53),
		19'((RECIP_ONE + 53) / 54),  19'((RECIP_ONE + 54) / 55),
		19'((RECIP_ONE + 55) / 56),  19'((RECIP_ONE + 56) / 57),
		19'((RECIP_ONE + 57) / 58),  19'((RECIP_ONE + 58) / 59),
		19'((RECIP_ONE + 59) / 60),  19'((RECIP_ONE + 60) / 61),
		19'((RECIP_ONE + 61) / 62),  19'((RECIP_ONE + 62) / 63)
	};

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		unique case (ph)
			PH_IDLE:     code = PH_IDLE_CODE;
			PH_FIXED:    code = PH_FIXED_CODE;
			PH_CHECK:    code = PH_CHECK_CODE;
			PH_AVERAGE:  code = PH_AVERAGE_CODE;
			PH_COMPLETE: code = PH_COMPLETE_CODE;
			default:     code = PH_IDLE_CODE;
		endcase
		return code;
	endfunction

endpackage

FILE: hw/rtl/agm_seq.sv
// ----------------------------------------------------------------------------
// Autorange gain measure sequencer
// Phase machine with settle counting, gain ranging and the scaled result.
// ----------------------------------------------------------------------------
module agm_seq
	import agm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic                     tick,
	input  logic                     start_request,
	input  logic [LEVEL_W-1:0]       sig_level,
	input  cfg_t                     cfg,
	input  logic [SRC_W-1:0]         settle_recip,
	input  logic                     polarity_neg,
	output logic [1:0]               gain_sel,
	output logic [2:0]               phase,
	output logic [PROG_W-1:0]        progress,
	output logic                     result_valid,
	output logic signed [RES_W-1:0]  result_value
);

	phase_t                   phase_q, phase_d;
	logic [TICK_W-1:0]        settle_q, settle_d;
	logic                     done_wait_q, done_wait_d;
	logic [1:0]               gain_q, gain_d;
	logic [PROG_W-1:0]        prog_q, prog_d;
	logic signed [RES_W-1:0]  result_q, result_d;
	logic                     res_valid_q, res_valid_d;

	logic [TICK_W-1:0]        st_eff;
	logic [TICK_W:0]          cnt;
	logic [11:0]              pct_num;
	logic [30:0]              pct_prod;
	logic [12:0]              pct;
	logic [PROG_W-1:0]        pct_sat;

	logic [17:0]              scaled;
	logic [19:0]              gain_recip;
	logic [37:0]              div_prod;
	logic [17:0]              mag;
	logic signed [RES_W-1:0]  mag_s;

	assign st_eff   = (cfg.settle_ticks == '0) ? TICK_W'(1) : cfg.settle_ticks;
	assign cnt      = {1'b0, settle_q} + (TICK_W + 1)'(1);
	assign pct_num  = 12'(cnt) * 12'(SETTLE_PCT);
	assign pct_prod = pct_num * settle_recip;
	assign pct      = pct_prod[30:SETTLE_SHIFT];
	assign pct_sat  = (pct > 13'(PROG_FULL)) ? PROG_FULL : pct[PROG_W-1:0];

	assign scaled     = {sig_level, 2'b00};
	assign gain_recip = (gain_q == GAIN_X10) ? RECIP_DIV10 : RECIP_DIV100;
	assign div_prod   = scaled * gain_recip;

	always_comb begin
		priority if (gain_q == GAIN_X1) begin
			mag = scaled;
		end else if (gain_q == GAIN_X10) begin
			mag = 18'(div_prod[37:DIV10_SHIFT]);
		end else begin
			mag = 18'(div_prod[37:DIV100_SHIFT]);
		end
	end

	assign mag_s = RES_W'(mag);

	always_comb begin
		phase_d     = phase_q;
		settle_d    = settle_q;
		done_wait_d = done_wait_q;
		gain_d      = gain_q;
		prog_d      = prog_q;
		result_d    = result_q;
		res_valid_d = 1'b0;
		if (tick) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (start_request) begin
						prog_d  = PROG_START;
						phase_d = cfg.auto_range ? PH_CHECK : PH_FIXED;
					end
				end
				PH_FIXED: begin
					prog_d  = PROG_FIXED;
					phase_d = PH_AVERAGE;
					unique case (cfg.fixed_gain)
						FG_X100: gain_d = GAIN_X100;
						FG_X10:  gain_d = GAIN_X10;
						FG_X1:   gain_d = GAIN_X1;
						FG_KEEP: gain_d = gain_q;
					endcase
				end
				PH_CHECK: begin
					prog_d = pct_sat;
					if (settle_q >= st_eff) begin
						settle_d = '0;
						priority if (sig_level < cfg.low_level) begin
							gain_d = GAIN_X100;
						end else if (sig_level < cfg.mid_level) begin
							if (gain_q == GAIN_X1) begin
								gain_d = GAIN_X10;
							end else if (gain_q == GAIN_X10) begin
								gain_d = GAIN_X100;
							end
						end else if (sig_level > cfg.high_level) begin
							gain_d = GAIN_X1;
						end else begin
							prog_d  = PROG_RANGE;
							phase_d = PH_AVERAGE;
						end
					end else begin
						settle_d = cnt[TICK_W-1:0];
					end
				end
				PH_AVERAGE: begin
					result_d    = polarity_neg ? -mag_s : mag_s;
					prog_d      = PROG_FULL;
					phase_d     = PH_COMPLETE;
					res_valid_d = 1'b1;
				end
				PH_COMPLETE: begin
					if (done_wait_q) begin
						done_wait_d = 1'b0;
						phase_d     = PH_IDLE;
					end else begin
						done_wait_d = 1'b1;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			settle_q    <= '0;
			done_wait_q <= 1'b0;
			gain_q      <= GAIN_X1;
			prog_q      <= '0;
			result_q    <= '0;
			res_valid_q <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			settle_q    <= settle_d;
			done_wait_q <= done_wait_d;
			gain_q      <= gain_d;
			prog_q      <= prog_d;
			result_q    <= result_d;
			res_valid_q <= res_valid_d;
		end
	end

	assign gain_sel     = gain_q;
	assign phase        = phase_code(phase_q);
	assign progress     = prog_q;
	assign result_valid = res_valid_q;
	assign result_value = result_q;

endmodule

FILE: hw/rtl/agm_peak.sv
// ----------------------------------------------------------------------------
// Autorange gain measure peak tracker
// Finds the largest signal sample of each window (the earliest on a tie) and latches the polarity.
// ----------------------------------------------------------------------------
module agm_peak
	import agm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample,
	input  logic [15:0]        sig_raw,
	input  logic [15:0]        cal_raw,
	input  logic [LEVEL_W-1:0] polarity_level,
	output logic               negative
);

	logic [WIN_W-1:0] win_cnt_q;
	logic [15:0]      peak_q;
	logic [15:0]      cal_pk_q;
	logic             neg_q;

	logic             take;
	logic [15:0]      peak_d;
	logic [15:0]      cal_pk_d;
	logic [WIN_W:0]   win_next;
	logic             win_end;

	assign take     = (win_cnt_q == '0) || (sig_raw > peak_q);
	assign peak_d   = take ? sig_raw : peak_q;
	assign cal_pk_d = take ? cal_raw : cal_pk_q;
	assign win_next = {1'b0, win_cnt_q} + (WIN_W + 1)'(1);
	assign win_end  = win_next >= (WIN_W + 1)'(WINDOW_SAMPLES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cnt_q <= '0;
			peak_q    <= '0;
			cal_pk_q  <= '0;
			neg_q     <= 1'b0;
		end else if (sample) begin
			if (win_end) begin
				neg_q     <= cal_pk_d < polarity_level;
				win_cnt_q <= '0;
				peak_q    <= '0;
				cal_pk_q  <= '0;
			end else begin
				win_cnt_q <= win_next[WIN_W-1:0];
				peak_q    <= peak_d;
				cal_pk_q  <= cal_pk_d;
			end
		end
	end

	assign negative = neg_q;

endmodule

FILE: hw/rtl/autorange_gain_measure_core.sv
// ----------------------------------------------------------------------------
// Autorange gain measure core
// Measurement sequencer with automatic gain ranging and a polarity tracker.
// ----------------------------------------------------------------------------
// The core takes one item per clock cycle while the output is not stalled and
// gives one result per item, in order. An accepted item waits in the input
// register until the output can take it; then its result is written into the
// result registers and out_valid rises. The input register frees itself in the
// same cycle that the result registers are taken, so a full stream runs at one
// item per cycle while out_ready stays high; a stalled output holds at most one
// item in each stage. Tick items (mode 0) drive the sequencer, sample items
// (mode 1) the peak tracker. Register writes take effect on the next edge and
// should only be made with no item in flight. There is no start-up clearing pass.
module autorange_gain_measure_core
	import agm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     mode,
	input  logic                     start_request,
	input  logic [LEVEL_W-1:0]       sig_level,
	input  logic [15:0]              sig_raw,
	input  logic [15:0]              cal_raw,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               gain_sel,
	output logic [2:0]               phase,
	output logic [PROG_W-1:0]        progress,
	output logic                     result_valid,
	output logic signed [RES_W-1:0]  result_value,
	output logic                     negative,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [15:0]              cfg_data
);

	cfg_t             cfg_q;
	logic [SRC_W-1:0] settle_recip_q;

	logic               valid_s1;
	logic               mode_s1;
	logic               start_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [15:0]        sig_s1;
	logic [15:0]        cal_s1;

	logic out_valid_q;
	logic step;

	assign cfg_ready = 1'b1;
	assign step      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || step;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_range     <= AUTO_RANGE_RST;
			cfg_q.fixed_gain     <= FIXED_GAIN_RST;
			cfg_q.low_level      <= LOW_LEVEL_RST;
			cfg_q.mid_level      <= MID_LEVEL_RST;
			cfg_q.high_level     <= HIGH_LEVEL_RST;
			cfg_q.settle_ticks   <= SETTLE_TICKS_RST;
			cfg_q.polarity_level <= POLARITY_LEVEL_RST;
			settle_recip_q       <= SETTLE_RECIP[SETTLE_TICKS_RST];
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_AUTO_RANGE:     cfg_q.auto_range     <= cfg_data[0];
				REG_FIXED_GAIN:     cfg_q.fixed_gain     <= cfg_data[1:0];
				REG_LOW_LEVEL:      cfg_q.low_level      <= cfg_data;
				REG_MID_LEVEL:      cfg_q.mid_level      <= cfg_data;
				REG_HIGH_LEVEL:     cfg_q.high_level     <= cfg_data;
				REG_SETTLE_TICKS: begin
					cfg_q.settle_ticks <= cfg_data[TICK_W-1:0];
					settle_recip_q     <= SETTLE_RECIP[cfg_data[TICK_W-1:0]];
				end
				REG_POLARITY_LEVEL: cfg_q.polarity_level <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			start_s1 <= start_request;
			level_s1 <= sig_level;
			sig_s1   <= sig_raw;
			cal_s1   <= cal_raw;
		end
	end

	agm_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.tick          (!mode_s1),
		.start_request (start_s1),
		.sig_level     (level_s1),
		.cfg           (cfg_q),
		.settle_recip  (settle_recip_q),
		.polarity_neg  (negative),
		.gain_sel      (gain_sel),
		.phase         (phase),
		.progress      (progress),
		.result_valid  (result_valid),
		.result_value  (result_value)
	);

	agm_peak u_peak (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample         (step && mode_s1),
		.sig_raw        (sig_s1),
		.cal_raw        (cal_s1),
		.polarity_level (cfg_q.polarity_level),
		.negative       (negative)
	);

endmodule

FILE: hw/rtl/agm_checker.sv
// ----------------------------------------------------------------------------
// Autorange gain measure checker
// Port-level assertions on the core, attached by bind.
// ----------------------------------------------------------------------------
`include "autorange_gain_measure_core_defines.svh"

module agm_checker
	import agm_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [1:0]               gain_sel,
	input logic [2:0]               phase,
	input logic [PROG_W-1:0]        progress,
	input logic                     result_valid,
	input logic signed [RES_W-1:0]  result_value,
	input logic                     negative
);

	`AGM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(gain_sel) && $stable(phase) && $stable(progress) && $stable(result_valid) && $stable(result_value) && $stable(negative), "Stalled result transaction changed")
	`AGM_ASSERT_SAME(a_result_phase, out_valid && result_valid, phase == PH_COMPLETE_CODE && progress == PROG_FULL, "New result outside the complete phase")
	`AGM_ASSERT_SAME(a_result_sign, out_valid && result_valid && !negative, !result_value[RES_W-1], "Positive polarity gave a negative result")
	`AGM_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready, "Input stalled without an output stall")

endmodule

bind autorange_gain_measure_core agm_checker u_agm_checker (.*);

FILE: verif/tb_autorange_gain_measure_core.sv
// ----------------------------------------------------------------------------
// Autorange gain measure core testbench
// Drives tick and sample transactions into the core and predicts every
// readout from a behavioural copy of the sequencer and the peak tracker,
// comparing each readout field by field. Register settings change between
// phases once all readouts are in, and both handshakes stall at random outside the calm phase.
// ----------------------------------------------------------------------------
module tb_autorange_gain_measure_core;
	timeunit 1ns;
	timeprecision 1ps;

	import agm_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int IDLE_PCT     = 13;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1650;
	localparam int MIN_WINDOWS  = 1;
	localparam int CALM_PHASE   = 3;

	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef struct packed {
		logic        mode;
		logic        start;
		logic [15:0] level;
		logic [15:0] sig;
		logic [15:0] cal;
	} meas_item_t;

	typedef struct packed {
		logic [1:0]       gain;
		logic [2:0]       phase;
		logic [PROG_W-1:0] progress;
		logic             rvalid;
		logic [RES_W-1:0] value;
		logic             neg;
	} readout_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = 1'b0;
	logic start_request = 1'b0;
	logic [LEVEL_W-1:0] sig_level = '0;
	logic [15:0] sig_raw = '0;
	logic [15:0] cal_raw = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] gain_sel;
	logic [2:0] phase;
	logic [PROG_W-1:0] progress;
	logic result_valid;
	logic signed [RES_W-1:0] result_value;
	logic negative;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	autorange_gain_measure_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.start_request (start_request),
		.sig_level     (sig_level),
		.sig_raw       (sig_raw),
		.cal_raw       (cal_raw),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.gain_sel      (gain_sel),
		.phase         (phase),
		.progress      (progress),
		.result_valid  (result_valid),
		.result_value  (result_value),
		.negative      (negative),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// Register copies.
	logic               c_auto   = AUTO_RANGE_RST;
	logic [1:0]         c_fixed  = FIXED_GAIN_RST;
	logic [LEVEL_W-1:0] c_low    = LOW_LEVEL_RST;
	logic [LEVEL_W-1:0] c_mid    = MID_LEVEL_RST;
	logic [LEVEL_W-1:0] c_high   = HIGH_LEVEL_RST;
	logic [TICK_W-1:0]  c_settle = SETTLE_TICKS_RST;
	logic [LEVEL_W-1:0] c_pol    = POLARITY_LEVEL_RST;

	// Sequencer and tracker state.
	logic [2:0]        seq_phase    = PH_IDLE_CODE;
	logic [TICK_W-1:0] seq_settle   = '0;
	logic              seq_done     = 1'b0;
	logic [1:0]        seq_gain     = GAIN_X1;
	logic [PROG_W-1:0] seq_progress = '0;
	int                trk_count    = 0;
	logic [15:0]       trk_peak     = '0;
	logic [15:0]       trk_cal      = '0;
	logic              trk_neg      = 1'b0;
	int                last_reading = 0;

	meas_item_t pending_items[$];
	readout_t   expected_readouts[$];

	int  pushed_count  = 0;
	int  checked_count = 0;
	int  fail_count    = 0;
	int  cycle_count   = 0;
	bit  in_taken      = 1'b0;
	bit  cfg_taken     = 1'b0;
	bit  calm          = 1'b0;

	int          gen_samples = 0;
	bit          win_flat    = 1'b0;
	bit          win_low_cal = 1'b0;
	logic [15:0] flat_value  = '0;

	task automatic apply_register(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			REG_AUTO_RANGE:     c_auto   = data[0];
			REG_FIXED_GAIN:     c_fixed  = data[1:0];
			REG_LOW_LEVEL:      c_low    = data;
			REG_MID_LEVEL:      c_mid    = data;
			REG_HIGH_LEVEL:     c_high   = data;
			REG_SETTLE_TICKS:   c_settle = data[TICK_W-1:0];
			REG_POLARITY_LEVEL: c_pol    = data;
			default: ;
		endcase
	endtask

	task automatic advance_measurement(input meas_item_t it, output readout_t r);
		int  st;
		int  cnt;
		int  pct;
		int  mag;
		int  divisor;
		logic fresh;
		fresh = 1'b0;
		if (it.mode == MODE_TICK) begin
			case (seq_phase)
				PH_IDLE_CODE: begin
					if (it.start) begin
						seq_progress = PROG_START;
						seq_phase = c_auto ? PH_CHECK_CODE : PH_FIXED_CODE;
					end
				end
				PH_FIXED_CODE: begin
					seq_progress = PROG_FIXED;
					seq_phase = PH_AVERAGE_CODE;
					case (c_fixed)
						FG_X100: seq_gain = GAIN_X100;
						FG_X10:  seq_gain = GAIN_X10;
						FG_X1:   seq_gain = GAIN_X1;
						default: ;
					endcase
				end
				PH_CHECK_CODE: begin
					st = (c_settle == 0) ? 1 : int'(c_settle);
					cnt = int'(seq_settle) + 1;
					pct = (50 * cnt) / st;
					seq_progress = (pct > 100) ? PROG_FULL : PROG_W'(pct);
					if (int'(seq_settle) >= st) begin
						seq_settle = '0;
						if (it.level < c_low) begin
							seq_gain = GAIN_X100;
						end else if (it.level < c_mid) begin
							if (seq_gain == GAIN_X1)
								seq_gain = GAIN_X10;
							else if (seq_gain == GAIN_X10)
								seq_gain = GAIN_X100;
						end else if (it.level > c_high) begin
							seq_gain = GAIN_X1;
						end else begin
							seq_progress = PROG_RANGE;
							seq_phase = PH_AVERAGE_CODE;
						end
					end else begin
						seq_settle = TICK_W'(cnt);
					end
				end
				PH_AVERAGE_CODE: begin
					case (seq_gain)
						GAIN_X1:  divisor = 1;
						GAIN_X10: divisor = 10;
						default:  divisor = 100;
					endcase
					mag = (int'(it.level) * 4) / divisor;
					last_reading = trk_neg ? -mag : mag;
					seq_progress = PROG_FULL;
					seq_phase = PH_COMPLETE_CODE;
					fresh = 1'b1;
				end
				PH_COMPLETE_CODE: begin
					if (seq_done) begin
						seq_done = 1'b0;
						seq_phase = PH_IDLE_CODE;
					end else begin
						seq_done = 1'b1;
					end
				end
				default: seq_phase = PH_IDLE_CODE;
			endcase
		end else begin
			if (trk_count == 0 || it.sig > trk_peak) begin
				trk_peak = it.sig;
				trk_cal = it.cal;
			end
			trk_count++;
			if (trk_count >= WINDOW_SAMPLES) begin
				trk_neg = (trk_cal < c_pol);
				trk_count = 0;
				trk_peak = '0;
				trk_cal = '0;
			end
		end
		r.gain = seq_gain;
		r.phase = seq_phase;
		r.progress = seq_progress;
		r.rvalid = fresh;
		r.value = last_reading[RES_W-1:0];
		r.neg = trk_neg;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s differs, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("autorange_gain_measure_core: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin : watch_ports
		meas_item_t acc;
		readout_t   want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_register(cfg_index, cfg_data);
				cfg_taken = 1'b1;
			end
			if (in_valid && in_ready) begin
				acc = {mode, start_request, sig_level, sig_raw, cal_raw};
				advance_measurement(acc, want);
				expected_readouts.push_back(want);
				in_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (expected_readouts.size() == 0) begin
					$display("%0t ns: readout with none expected, actual phase %0d value %0d",
						$time, phase, result_value);
					fail_count++;
				end else begin
					want = expected_readouts.pop_front();
					check_field("gain_sel", int'(want.gain), int'(gain_sel));
					check_field("phase", int'(want.phase), int'(phase));
					check_field("progress", int'(want.progress), int'(progress));
					check_field("result_valid", int'(want.rvalid), int'(result_valid));
					check_field("result_value", int'($signed(want.value)),
						int'(result_value));
					check_field("negative", int'(want.neg), int'(negative));
					checked_count++;
				end
			end
		end
	end

	always @(negedge clk) begin : drive_items
		meas_item_t nxt;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					nxt = pending_items.pop_front();
					mode <= nxt.mode;
					start_request <= nxt.start;
					sig_level <= nxt.level;
					sig_raw <= nxt.sig;
					cal_raw <= nxt.cal;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			in_taken = 1'b0;
			out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_taken);
		cfg_taken = 1'b0;
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (checked_count != pushed_count);
	endtask

	task automatic push_tick(input logic start, input logic [15:0] level);
		meas_item_t it;
		it = {MODE_TICK, start, level, 16'($urandom), 16'($urandom)};
		pending_items.push_back(it);
		pushed_count++;
	endtask

	task automatic push_sample(input logic [15:0] sig, input logic [15:0] cal);
		meas_item_t it;
		it = {MODE_SAMPLE, 1'($urandom), 16'($urandom), sig, cal};
		pending_items.push_back(it);
		pushed_count++;
		gen_samples++;
	endtask

	// Each window is either flat or random in the signal, and its calibration
	// samples are either spread over the full range or kept near the threshold.
	task automatic push_random_sample();
		logic [15:0] sig;
		logic [15:0] cal;
		if (gen_samples % WINDOW_SAMPLES == 0) begin
			win_flat = ($urandom_range(0, 3) == 0);
			win_low_cal = 1'($urandom_range(0, 1));
			flat_value = 16'($urandom);
		end
		sig = win_flat ? flat_value : 16'($urandom);
		cal = win_low_cal ? 16'($urandom_range(0, 1500)) : 16'($urandom);
		push_sample(sig, cal);
	endtask

	function automatic logic [15:0] pick_level();
		int lo;
		lo = (c_low > c_mid) ? c_low : c_mid;
		if ($urandom_range(0, 9) < 7 && lo <= int'(c_high))
			return 16'($urandom_range(lo, c_high));
		return 16'($urandom);
	endfunction

	task automatic push_measurement();
		int st;
		repeat ($urandom_range(0, 2)) push_tick(1'($urandom_range(0, 1)), 16'($urandom));
		push_tick(1'b1, 16'($urandom));
		st = (c_settle == 0) ? 1 : int'(c_settle);
		repeat (st + 4) begin
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 6)) push_random_sample();
			push_tick($urandom_range(0, 7) == 0, pick_level());
		end
	endtask

	task automatic configure(input int idx);
		logic a;
		logic [1:0] f;
		int lo;
		int mi;
		int hi;
		int st;
		int pl;
		if (idx == 0) begin
			a = 1'b0; f = FG_X100; lo = 0; mi = 0; hi = 0; st = 0; pl = 0;
		end else if (idx == 1) begin
			a = 1'b1; f = FG_KEEP; lo = 65535; mi = 65535; hi = 65535; st = 63; pl = 65535;
		end else begin
			a = ($urandom_range(0, 9) < 7);
			f = 2'($urandom);
			if ($urandom_range(0, 3) != 0) begin
				lo = $urandom_range(0, 2000);
				mi = lo + $urandom_range(0, 10000);
				hi = mi + $urandom_range(0, 65535 - mi);
			end else begin
				lo = $urandom_range(0, 65535);
				mi = $urandom_range(0, 65535);
				hi = $urandom_range(0, 65535);
			end
			st = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 63);
			pl = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1500) : $urandom_range(0, 65535);
		end
		write_reg(REG_AUTO_RANGE, 16'(a));
		write_reg(REG_FIXED_GAIN, 16'(f));
		write_reg(REG_LOW_LEVEL, 16'(lo));
		write_reg(REG_MID_LEVEL, 16'(mi));
		write_reg(REG_HIGH_LEVEL, 16'(hi));
		write_reg(REG_SETTLE_TICKS, 16'(st));
		write_reg(REG_POLARITY_LEVEL, 16'(pl));
	endtask

	initial begin : stimulus
		int phase_idx;
		int random_base;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A settle count of zero acts as one, so every second check tick decides.
		write_reg(REG_SETTLE_TICKS, 16'd0);
		push_sample(16'h0000, 16'h0000);
		push_sample(16'hFFFF, 16'hFFFF);
		push_tick(1'b0, 16'd0);
		push_tick(1'b1, 16'hFFFF);
		push_tick(1'b0, 16'd0);
		push_tick(1'b0, 16'd0);
		push_tick(1'b1, 16'd0);
		push_tick(1'b0, 16'd600);
		push_tick(1'b0, 16'hFFFF);
		push_tick(1'b0, 16'hFFFF);
		push_tick(1'b0, 16'd1000);
		push_tick(1'b0, 16'd1000);
		push_tick(1'b0, 16'd1000);
		push_tick(1'b0, 16'd1000);
		push_tick(1'b0, 16'hFFFF);
		push_tick(1'b0, 16'hFFFF);
		push_tick(1'b0, 16'd20000);
		push_tick(1'b0, 16'd20000);
		push_tick(1'b0, 16'hFFFF);
		push_tick(1'b1, 16'd0);
		push_tick(1'b0, 16'd0);
		wait_drained();

		write_reg(REG_AUTO_RANGE, 16'd0);
		write_reg(REG_FIXED_GAIN, 16'(FG_X100));
		push_tick(1'b1, 16'd0);
		push_tick(1'b0, 16'd0);
		push_tick(1'b0, 16'hFFFF);
		push_tick(1'b0, 16'd0);
		push_tick(1'b0, 16'd0);
		wait_drained();

		phase_idx = 0;
		random_base = pushed_count;
		while (pushed_count - random_base < RANDOM_ITEMS || phase_idx <= CALM_PHASE ||
			gen_samples < MIN_WINDOWS * WINDOW_SAMPLES) begin
			calm = (phase_idx == CALM_PHASE);
			configure(phase_idx);
			repeat ($urandom_range(1, 4)) push_measurement();
			if (calm || $urandom_range(0, 1))
				repeat ($urandom_range(100, 600)) push_random_sample();
			wait_drained();
			phase_idx++;
		end
		calm = 1'b0;

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && expected_readouts.size() == 0)
			$display("autorange_gain_measure_core: match");
		else
			$display("autorange_gain_measure_core: mismatch");
		$finish;
	end

endmodule

FILE: autorange_gain_measure_core.f
+incdir+hw/rtl
hw/rtl/agm_pkg.sv
hw/rtl/agm_seq.sv
hw/rtl/agm_peak.sv
hw/rtl/autorange_gain_measure_core.sv
hw/rtl/agm_checker.sv
verif/tb_autorange_gain_measure_core.sv
